/* rtl/mfca_pkg.sv */
// Shared types and constants for the Modbus frame CRC appender.
package mfca_pkg;

  // Trailer select codes held in the mode register
  localparam logic MODE_PAD   = 1'b0;
  localparam logic MODE_ASCII = 1'b1;

  // CRC-16/Modbus constants
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Trailer bytes
  localparam logic [7:0] PAD_CHAR   = 8'h00;
  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] LF_CHAR    = 8'h0A;

  // Most trailer pad bytes that fit one frame burst
  localparam int unsigned MAX_PADS = 8;

  // Queue depth between front and back (power of two)
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One classified byte handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        mode;
    logic [15:0] crc;
  } mfca_entry_t;

endpackage

/* rtl/modbus_frame_crc_appender.sv */
// Top level of the Modbus RTU frame generator with CRC-16 appender.
//
// Message bytes pass through unchanged while a CRC-16/Modbus (poly 0xA001
// reflected, start 0xFFFF) runs over them; after the byte flagged last the
// block adds CRC low, CRC high and a trailer (PAD_BYTES zero bytes, at most
// eight, when frame_mode is 0; colon CR LF when it is 1), then restarts the
// CRC. Ordinary bytes stream back to back unless the output stalls. A closing
// byte holds the output sequencer while it sends the byte, CRC low, CRC high
// and the trailer, one output beat per cycle while out_ready_i allows; the
// input queues bytes in a two-entry queue, stalling when full. The user must
// write frame_mode via cfg_we_i/cfg_wdata_i only while idle; it is unchecked.
module modbus_frame_crc_appender import mfca_pkg::*; #(
  parameter int unsigned PAD_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  mfca_entry_t       push_entry, head_entry;
  logic              q_push, q_pop, q_full, q_empty;
  logic [QCNT_W-1:0] q_count;
  logic              back_at_first;

  mfca_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry)
  );

  mfca_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .head_o  (head_entry),
    .full_o  (q_full),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  mfca_back #(
    .PAD_BYTES (PAD_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_entry),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .at_first_o  (back_at_first),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  // Queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCNT_W'(QDEPTH))
    else $error("queue occupancy above depth");

  // Sequencer is back at the start while a frame's closing beat waits
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |-> back_at_first)
    else $error("sequencer not restarted after frame end");

  // Mid-frame the beat being expanded is still queued
  a_mid_frame_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !back_at_first |-> !q_empty)
    else $error("sequencer mid-frame with empty queue");

endmodule

/* rtl/mfca_front.sv */
// Front end: accepts message bytes, folds the CRC and classifies each beat.
module mfca_front import mfca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output mfca_entry_t q_entry_o
);

  logic        mode_q;
  logic [15:0] crc_q, crc_d, crc_fold;

  // Fold one byte into a reflected CRC-16, one bit per step
  function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign crc_fold   = fold_byte(crc_q, in_byte_i);

  // Fold each accepted byte into the CRC, restart it after a message's closing byte
  always_comb begin
    crc_d = crc_q;
    if (q_push_o) begin
      crc_d = in_last_i ? CRC_INIT : crc_fold;
    end
  end

  // Tag the beat with the folded CRC and the trailer mode
  always_comb begin
    q_entry_o.data = in_byte_i;
    q_entry_o.last = in_last_i;
    q_entry_o.mode = mode_q;
    q_entry_o.crc  = crc_fold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_INIT;
      mode_q <= MODE_PAD;
    end else begin
      crc_q <= crc_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

endmodule

/* rtl/mfca_queue.sv */
// Short register queue that decouples the front end from the sequencer.
module mfca_queue import mfca_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mfca_entry_t       entry_i,
  input  logic              pop_i,
  output mfca_entry_t       head_o,
  output logic              full_o,
  output logic              empty_o,
  output logic [QCNT_W-1:0] count_o
);

  mfca_entry_t       mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign head_o  = mem_q[rd_ptr_q];

  // Track occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Hold entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

/* rtl/mfca_back.sv */
// Back end: expands each queued beat into frame bytes behind an output register.
module mfca_back import mfca_pkg::*; #(
  parameter int unsigned PAD_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mfca_entry_t head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        at_first_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o
);

  localparam int unsigned PADS     = (PAD_BYTES > MAX_PADS) ? MAX_PADS : PAD_BYTES;
  localparam int unsigned MAX_STEP = 2 + ((PADS > 3) ? PADS : 3);
  localparam int unsigned STEP_W   = $clog2(MAX_STEP + 1);

  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, byte_sel;
  logic              out_last_q, last_sel;
  logic              load, emit, fin;

  assign load        = !out_valid_q || out_ready_i;
  assign emit        = load && !empty_i;
  assign pop_o       = emit && fin;
  assign at_first_o  = (step_q == '0);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // Pick the frame byte for the current step
  always_comb begin
    byte_sel = head_i.data;
    fin      = 1'b0;
    last_sel = 1'b0;
    if (step_q == '0) begin
      fin = !head_i.last;
    end else if (step_q == STEP_W'(1)) begin
      byte_sel = head_i.crc[7:0];
    end else if (step_q == STEP_W'(2)) begin
      byte_sel = head_i.crc[15:8];
      fin      = (head_i.mode == MODE_PAD) && (PADS == 0);
      last_sel = fin;
    end else if (head_i.mode == MODE_PAD) begin
      byte_sel = PAD_CHAR;
      fin      = (step_q == STEP_W'(2 + PADS));
      last_sel = fin;
    end else if (step_q == STEP_W'(3)) begin
      byte_sel = COLON_CHAR;
    end else if (step_q == STEP_W'(4)) begin
      byte_sel = CR_CHAR;
    end else begin
      byte_sel = LF_CHAR;
      fin      = 1'b1;
      last_sel = 1'b1;
    end
  end

  // Advance through the frame, restart on the closing byte
  always_comb begin
    step_d = step_q;
    if (pop_o) begin
      step_d = '0;
    end else if (emit) begin
      step_d = step_q + 1'b1;
    end
  end

  // Load or drain the output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= byte_sel;
      out_last_q <= last_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
